// ===== rtl/core/lkv_pkg.sv =====
// lkv_pkg: shared types and constants of the LRU key-value cache.
// Holds operation codes, cell command and status structs.
// No dependencies.
`default_nettype none

package lkv_pkg;

  // operation codes carried by in_op
  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_PUT    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // configuration register indexes
  localparam logic REG_CAPACITY = 1'b0;

  localparam int          CAP_W     = 5;
  localparam logic [4:0]  CAP_RESET = 5'd16;
  localparam int          RD_W      = 16;
  localparam int          CNT_W     = 32;
  localparam int          APB_W     = 32;
  localparam int          ADDR_W    = 3;

  // per-cell update issued by the control logic
  typedef enum logic [1:0] {
    CELL_IDLE,
    CELL_TOUCH,
    CELL_DROP,
    CELL_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     wr_value;  // touch also overwrites the value (put hit)
    logic     evict;     // insert removes the least recent entry
  } cell_cmd_t;

  typedef struct packed {
    logic valid;
    logic match;
    logic victim;        // valid and ranked least recent
  } cell_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/lkv_cell.sv =====
// lkv_cell: one cache entry (key, value, valid bit, recency rank).
// Compares its key against the lookup key and applies broadcast updates.
// Depends on lkv_pkg.
`default_nettype none

module lkv_cell #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 16,
  parameter int RANK_W     = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lkv_pkg::cell_cmd_t    cmd,
  input  wire logic                  sel,
  input  wire logic [RANK_W-1:0]     ref_rank,
  input  wire logic [RANK_W-1:0]     lru_rank,
  input  wire logic [KEY_BITS-1:0]   lookup_key,
  input  wire logic [VALUE_BITS-1:0] wr_value,
  output lkv_pkg::cell_stat_t        stat,
  output logic [RANK_W-1:0]          rank,
  output logic [VALUE_BITS-1:0]      value
);

  logic                  valid_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [RANK_W-1:0]     rank_r;

  assign stat.valid  = valid_r;
  assign stat.match  = valid_r && (key_r == lookup_key);
  assign stat.victim = valid_r && (rank_r == lru_rank);
  assign rank        = rank_r;
  assign value       = value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        lkv_pkg::CELL_TOUCH: begin
          if (sel) begin
            rank_r <= '0;
            if (cmd.wr_value) value_r <= wr_value;
          end else if (valid_r && rank_r < ref_rank) begin
            rank_r <= rank_r + RANK_W'(1);
          end
        end
        lkv_pkg::CELL_DROP: begin
          if (sel) begin
            valid_r <= 1'b0;
          end else if (valid_r && rank_r > ref_rank) begin
            rank_r <= rank_r - RANK_W'(1);
          end
        end
        lkv_pkg::CELL_INSERT: begin
          if (sel) begin
            valid_r <= 1'b1;
            key_r   <= lookup_key;
            value_r <= wr_value;
            rank_r  <= '0;
          end else if (cmd.evict && stat.victim) begin
            valid_r <= 1'b0;
          end else if (valid_r) begin
            rank_r <= rank_r + RANK_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lru_key_value_cache_core.sv =====
// Fully associative LRU key-value cache: get, put and remove on register cells.
// An accepted transaction is held in the input register, then in the result register, which raises out_valid.
// Throughput one per cycle while out_ready stays high. The entry state is updated at the edge
// that moves an item into the result register. Reset (synchronous, rst_n low) clears all valid
// bits, occupancy, both counters, the pipeline valid flags, and sets capacity to 16.
// Keys, values and ranks are not reset. Depends on lkv_pkg and lkv_cell.
`default_nettype none

module lru_key_value_cache_core #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_op,
  input  wire logic [KEY_BITS-1:0]         in_key,
  input  wire logic [VALUE_BITS-1:0]       in_new_value,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_found,
  output logic [lkv_pkg::RD_W-1:0]         out_read_value,
  output logic [lkv_pkg::CNT_W-1:0]        out_hit_total,
  output logic [lkv_pkg::CNT_W-1:0]        out_miss_total,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lkv_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lkv_pkg::APB_W-1:0]   pwdata,
  output logic [lkv_pkg::APB_W-1:0]        prdata,
  output logic                             pready
);

  localparam int RANK_W = $clog2(ENTRIES);
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > lkv_pkg::CAP_W) ? OCC_W : lkv_pkg::CAP_W;
  localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

  // ---------------------------------------------------------------------------
  // Configuration: capacity register, written in the APB access phase.
  // ---------------------------------------------------------------------------
  logic [lkv_pkg::CAP_W-1:0] cap_r;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == lkv_pkg::REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkv_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[lkv_pkg::CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == lkv_pkg::REG_CAPACITY) ?
                  lkv_pkg::APB_W'(cap_r) : '0;

  // ---------------------------------------------------------------------------
  // Input register. Advance into the result register when that one is free
  // or being drained in the same cycle.
  // ---------------------------------------------------------------------------
  logic                  s1_valid_r;
  logic [1:0]            s1_op_r;
  logic [KEY_BITS-1:0]   s1_key_r;
  logic [VALUE_BITS-1:0] s1_val_r;
  logic                  s1_adv;

  assign s1_adv   = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r  <= in_op;
      s1_key_r <= in_key;
      s1_val_r <= in_new_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Entry cells and their status.
  // ---------------------------------------------------------------------------
  lkv_pkg::cell_cmd_t  cmd;
  lkv_pkg::cell_stat_t stat   [ENTRIES];
  logic [RANK_W-1:0]   rank   [ENTRIES];
  logic [VALUE_BITS-1:0] value [ENTRIES];
  logic [ENTRIES-1:0]  sel;
  logic [ENTRIES-1:0]  match_v;
  logic [ENTRIES-1:0]  valid_v;
  logic [ENTRIES-1:0]  victim_v;
  logic [RANK_W-1:0]   hit_rank;
  logic [VALUE_BITS-1:0] hit_value;
  logic [OCC_W-1:0]    occ_r;
  logic [OCC_W-1:0]    occ_m1;

  assign occ_m1 = occ_r - OCC_W'(1);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkv_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .RANK_W     (RANK_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .sel        (sel[i]),
      .ref_rank   (hit_rank),
      .lru_rank   (occ_m1[RANK_W-1:0]),
      .lookup_key (s1_key_r),
      .wr_value   (s1_val_r),
      .stat       (stat[i]),
      .rank       (rank[i]),
      .value      (value[i])
    );
    assign match_v[i]  = stat[i].match;
    assign valid_v[i]  = stat[i].valid;
    assign victim_v[i] = stat[i].victim;
  end

  // Keys are unique among valid entries, so at most one cell matches:
  // OR the masked rank and value of every cell.
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank  = hit_rank  | (rank[i]  & {RANK_W{match_v[i]}});
      hit_value = hit_value | (value[i] & {VALUE_BITS{match_v[i]}});
    end
  end

  // ---------------------------------------------------------------------------
  // Decide the operation.
  // ---------------------------------------------------------------------------
  logic                  hit;
  logic [CMP_W-1:0]      cap_eff;
  logic                  need_evict;
  logic [ENTRIES-1:0]    free_v;
  logic [ENTRIES-1:0]    slot_oh;
  logic [OCC_W-1:0]      occ_nxt;

  assign hit = |match_v;

  // Clamp capacity: zero acts as one, above ENTRIES acts as ENTRIES.
  always_comb begin
    cap_eff = CMP_W'(cap_r);
    if (cap_r == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_eff > ENTRIES_C) begin
      cap_eff = ENTRIES_C;
    end
  end

  assign need_evict = CMP_W'(occ_r) >= cap_eff;

  // Lowest free cell after a possible eviction: isolate the lowest set bit.
  assign free_v  = ~valid_v | (victim_v & {ENTRIES{need_evict}});
  assign slot_oh = free_v & (~free_v + ENTRIES'(1));

  always_comb begin
    cmd     = '{op: lkv_pkg::CELL_IDLE, wr_value: 1'b0, evict: 1'b0};
    sel     = '0;
    occ_nxt = occ_r;
    if (s1_adv) begin
      unique case (s1_op_r)
        lkv_pkg::OP_GET: begin
          if (hit) begin
            cmd.op = lkv_pkg::CELL_TOUCH;
            sel    = match_v;
          end
        end
        lkv_pkg::OP_PUT: begin
          if (hit) begin
            cmd.op       = lkv_pkg::CELL_TOUCH;
            cmd.wr_value = 1'b1;
            sel          = match_v;
          end else begin
            cmd.op    = lkv_pkg::CELL_INSERT;
            cmd.evict = need_evict;
            sel       = slot_oh;
            if (!need_evict) occ_nxt = occ_r + OCC_W'(1);
          end
        end
        lkv_pkg::OP_REMOVE: begin
          if (hit) begin
            cmd.op  = lkv_pkg::CELL_DROP;
            sel     = match_v;
            occ_nxt = occ_r - OCC_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Hit and miss counters, and the result register.
  // ---------------------------------------------------------------------------
  logic [lkv_pkg::CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [lkv_pkg::CNT_W-1:0] miss_cnt_r, miss_cnt_nxt;
  logic                      get_hit;
  logic [VALUE_BITS+lkv_pkg::RD_W-1:0] rd_ext;

  assign get_hit      = (s1_op_r == lkv_pkg::OP_GET) && hit;
  assign hit_cnt_nxt  = hit_cnt_r + lkv_pkg::CNT_W'(get_hit);
  assign miss_cnt_nxt = miss_cnt_r +
                        lkv_pkg::CNT_W'((s1_op_r == lkv_pkg::OP_GET) && !hit);
  assign rd_ext       = {{lkv_pkg::RD_W{1'b0}}, hit_value};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (s1_adv) begin
        hit_cnt_r  <= hit_cnt_nxt;
        miss_cnt_r <= miss_cnt_nxt;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // hold the result payload until the next transaction replaces it
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_found      <= get_hit;
      out_read_value <= get_hit ? rd_ext[lkv_pkg::RD_W-1:0] : '0;
      out_hit_total  <= hit_cnt_nxt;
      out_miss_total <= miss_cnt_nxt;
    end
  end

endmodule

`default_nettype wire
